FILE: design/clp_pkg.sv
// Package for the command line parser: token format, result codes and constants.
// Used by clp_front, clp_queue, clp_back and the top level.
package clp_pkg;

  localparam int MAX_MESSAGE = 64;
  localparam int LEN_W       = $clog2(MAX_MESSAGE + 1);
  localparam int WORD_LEN    = 6;
  localparam int WLEN_W      = $clog2(WORD_LEN + 1);
  localparam int VALUE_W     = 16;
  localparam int SUM_W       = VALUE_W + 4;
  localparam int Q_DEPTH     = 2;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [SUM_W-1:0] VALUE_MAX = SUM_W'(65535);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] UP_HEX_OFS = 8'h37;
  localparam logic [7:0] LO_HEX_OFS = 8'h57;

  // Command words, first byte in the low lane.
  localparam logic [WORD_LEN-1:0][7:0] WORD_MAC    = 48'h00_00_00_63_61_6d;
  localparam logic [WORD_LEN-1:0][7:0] WORD_ID     = 48'h00_00_00_00_64_69;
  localparam logic [WORD_LEN-1:0][7:0] WORD_STATUS = 48'h73_75_74_61_74_73;
  localparam logic [WORD_LEN-1:0][7:0] WORD_DEC    = 48'h00_00_00_63_65_64;

  localparam logic [WLEN_W-1:0] LEN_MAC    = WLEN_W'(3);
  localparam logic [WLEN_W-1:0] LEN_ID     = WLEN_W'(2);
  localparam logic [WLEN_W-1:0] LEN_STATUS = WLEN_W'(6);
  localparam logic [WLEN_W-1:0] LEN_DEC    = WLEN_W'(3);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CMD_ERR = 2'd1,
    ST_ARG_ERR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_MAC    = 2'd0,
    KIND_ID     = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_DEC    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RADIX_OCTAL  = 2'd0,
    RADIX_BINARY = 2'd1,
    RADIX_HEX    = 2'd2
  } radix_t;

  typedef enum logic [1:0] {
    ARG_LEAD   = 2'd0,
    ARG_PREFIX = 2'd1,
    ARG_DIGITS = 2'd2
  } argpos_t;

  typedef struct packed {
    logic       is_end;
    logic       is_ws;
    logic [7:0] lower;
    logic       is_zero;
    logic       is_b;
    logic       is_x;
    logic       hex_ok;
    logic [3:0] digit;
  } token_t;

endpackage

FILE: design/clp_front.sv
// Front end: accepts bytes and the end marker and classifies each into a token.
// Depends on clp_pkg.
module clp_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_character,
  input  logic            in_is_end,
  output logic            push_valid,
  input  logic            push_ready,
  output clp_pkg::token_t push_token
);
  import clp_pkg::*;

  logic [7:0] c;

  assign c          = in_character;
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  always_comb begin
    push_token         = '0;
    push_token.is_end  = in_is_end;
    push_token.is_ws   = (c == CH_SPACE) || (c == CH_TAB);
    push_token.lower   = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
    push_token.is_zero = (c == CH_ZERO);
    push_token.is_b    = (c == CH_LO_B);
    push_token.is_x    = (c == CH_LO_X);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      push_token.hex_ok = 1'b1;
      push_token.digit  = 4'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      push_token.hex_ok = 1'b1;
      push_token.digit  = 4'(c - LO_HEX_OFS);
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      push_token.hex_ok = 1'b1;
      push_token.digit  = 4'(c - UP_HEX_OFS);
    end
  end

endmodule

FILE: design/clp_queue.sv
// Short token queue between the front end and the back end.
// Depends on clp_pkg.
module clp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  clp_pkg::token_t push_token,
  output logic            pop_valid,
  input  logic            pop_ready,
  output clp_pkg::token_t pop_token
);
  import clp_pkg::*;

  token_t              mem_r [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_token  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

FILE: design/clp_back.sv
// Back end: line state, command word match, radix literal accumulation, result register.
// Depends on clp_pkg.
module clp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  clp_pkg::token_t pop_token,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic [1:0]      out_command_kind,
  output logic [15:0]     out_value
);
  import clp_pkg::*;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_MESSAGE);

  logic [LEN_W-1:0]             len_r, len_nxt;
  logic                         split_r, split_nxt;
  logic [WORD_LEN-1:0][7:0]     word_r, word_nxt;
  logic [WLEN_W-1:0]            wlen_r, wlen_nxt;
  logic                         wlong_r, wlong_nxt;
  argpos_t                      apos_r, apos_nxt;
  radix_t                       radix_r, radix_nxt;
  logic [VALUE_W-1:0]           acc_r, acc_nxt;
  logic                         bad_r, bad_nxt;

  logic                         out_valid_r, out_valid_nxt;
  status_t                      status_r, status_nxt;
  kind_t                        kind_r, kind_nxt;
  logic [VALUE_W-1:0]           value_r, value_nxt;

  logic                         take;
  radix_t                       dig_radix;
  logic                         dig_take;
  logic                         dig_ok;
  logic [SUM_W-1:0]             sum;

  assign pop_ready        = !pop_token.is_end || !out_valid_r || out_ready;
  assign take             = pop_valid && pop_ready;
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_command_kind = kind_r;
  assign out_value        = value_r;

  always_comb begin
    dig_radix = radix_r;
    dig_take  = 1'b0;
    if (apos_r == ARG_PREFIX) begin
      dig_radix = RADIX_OCTAL;
      dig_take  = !pop_token.is_b && !pop_token.is_x;
    end else if (apos_r == ARG_DIGITS) begin
      dig_take  = 1'b1;
    end
    case (dig_radix)
      RADIX_BINARY: begin
        dig_ok = pop_token.hex_ok && (pop_token.digit < 4'd2);
        sum    = {3'b000, acc_r, 1'b0} + SUM_W'(pop_token.digit);
      end
      RADIX_HEX: begin
        dig_ok = pop_token.hex_ok;
        sum    = {acc_r, 4'b0000} + SUM_W'(pop_token.digit);
      end
      default: begin
        dig_ok = pop_token.hex_ok && (pop_token.digit < 4'd8);
        sum    = {1'b0, acc_r, 3'b000} + SUM_W'(pop_token.digit);
      end
    endcase
  end

  always_comb begin
    len_nxt       = len_r;
    split_nxt     = split_r;
    word_nxt      = word_r;
    wlen_nxt      = wlen_r;
    wlong_nxt     = wlong_r;
    apos_nxt      = apos_r;
    radix_nxt     = radix_r;
    acc_nxt       = acc_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;

    if (take && !pop_token.is_end) begin
      if (len_r < LEN_MAX) begin
        len_nxt = len_r + 1'b1;
      end
      if (!split_r && pop_token.is_ws) begin
        split_nxt = 1'b1;
      end else if (!split_r) begin
        if (wlen_r < WLEN_W'(WORD_LEN)) begin
          word_nxt[wlen_r] = pop_token.lower;
          wlen_nxt         = wlen_r + 1'b1;
        end else begin
          wlong_nxt = 1'b1;
        end
      end else begin
        case (apos_r)
          ARG_LEAD: begin
            if (!pop_token.is_zero) begin
              bad_nxt = 1'b1;
            end
            apos_nxt = ARG_PREFIX;
          end
          ARG_PREFIX: begin
            apos_nxt = ARG_DIGITS;
            if (pop_token.is_b) begin
              radix_nxt = RADIX_BINARY;
            end else if (pop_token.is_x) begin
              radix_nxt = RADIX_HEX;
            end else begin
              radix_nxt = RADIX_OCTAL;
            end
          end
          default: begin
          end
        endcase
        if (dig_take) begin
          if (!dig_ok) begin
            bad_nxt = 1'b1;
          end else if (!bad_r) begin
            if (sum > VALUE_MAX) begin
              bad_nxt = 1'b1;
              acc_nxt = '0;
            end else begin
              acc_nxt = sum[VALUE_W-1:0];
            end
          end
        end
      end
    end

    if (take && pop_token.is_end) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      kind_nxt      = KIND_MAC;
      value_nxt     = '0;
      if (len_r >= LEN_MAX || wlong_r) begin
        status_nxt = ST_CMD_ERR;
      end else if (wlen_r == LEN_MAC && word_r == WORD_MAC) begin
        kind_nxt = KIND_MAC;
      end else if (wlen_r == LEN_ID && word_r == WORD_ID) begin
        kind_nxt = KIND_ID;
      end else if (wlen_r == LEN_STATUS && word_r == WORD_STATUS) begin
        kind_nxt = KIND_STATUS;
      end else if (wlen_r == LEN_DEC && word_r == WORD_DEC) begin
        kind_nxt = KIND_DEC;
        if (bad_r || apos_r == ARG_LEAD) begin
          status_nxt = ST_ARG_ERR;
        end else begin
          value_nxt = acc_r;
        end
      end else begin
        status_nxt = ST_CMD_ERR;
      end
      len_nxt   = '0;
      split_nxt = 1'b0;
      word_nxt  = '0;
      wlen_nxt  = '0;
      wlong_nxt = 1'b0;
      apos_nxt  = ARG_LEAD;
      radix_nxt = RADIX_OCTAL;
      acc_nxt   = '0;
      bad_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      split_r     <= 1'b0;
      word_r      <= '0;
      wlen_r      <= '0;
      wlong_r     <= 1'b0;
      apos_r      <= ARG_LEAD;
      radix_r     <= RADIX_OCTAL;
      acc_r       <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      split_r     <= split_nxt;
      word_r      <= word_nxt;
      wlen_r      <= wlen_nxt;
      wlong_r     <= wlong_nxt;
      apos_r      <= apos_nxt;
      radix_r     <= radix_nxt;
      acc_r       <= acc_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    kind_r   <= kind_nxt;
    value_r  <= value_nxt;
  end

endmodule

FILE: design/command_line_parser_with_radix_literal.sv
// Top level of the command line parser with radix literal argument.
// Depends on clp_pkg, clp_front, clp_queue and clp_back.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_character[7:0], in_is_end
//   out     | output    | out_valid / out_ready | out_status[1:0], out_command_kind[1:0],
//           |           |                       | out_value[15:0]
//
// One byte or end marker is taken per cycle while the queue has room; the back
// end retires one token per cycle unless an end marker waits on a held result.
// A result's end marker is written to the queue, then read into the result register.
// rst_n is synchronous, active low, and clears the queue and all line state.
// A stalled result holds only end markers in the back end; bytes keep flowing until the
// two-entry queue fills behind the next end marker.
module command_line_parser_with_radix_literal (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  input  logic        in_is_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [1:0]  out_command_kind,
  output logic [15:0] out_value
);
  import clp_pkg::*;

  logic   push_valid, push_ready;
  token_t push_token;
  logic   pop_valid, pop_ready;
  token_t pop_token;

  clp_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .in_is_end    (in_is_end),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_token   (push_token)
  );

  clp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_token (push_token),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_token  (pop_token)
  );

  clp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_token        (pop_token),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_command_kind (out_command_kind),
    .out_value        (out_value)
  );

  a_cmd_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CMD_ERR |-> out_command_kind == KIND_MAC)
    else $error("command error with nonzero kind");

  a_value_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == '0)
    else $error("nonzero value on error result");

  a_value_needs_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_kind != KIND_DEC |-> out_value == '0)
    else $error("nonzero value on non-dec result");

  a_arg_err_is_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ARG_ERR |-> out_command_kind == KIND_DEC)
    else $error("argument error on non-dec command");

endmodule
